// ----- src/i2crm_pkg.sv -----
package i2crm_pkg;

  // Bus sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_START_A = 4'd1,
    PH_START_B = 4'd2,
    PH_BIT_LO  = 4'd3,
    PH_BIT_HI  = 4'd4,
    PH_ACK_LO  = 4'd5,
    PH_ACK_HI  = 4'd6,
    PH_RBIT_LO = 4'd7,
    PH_RBIT_HI = 4'd8,
    PH_RACK_LO = 4'd9,
    PH_RACK_HI = 4'd10,
    PH_STOP_A  = 4'd11,
    PH_STOP_B  = 4'd12,
    PH_STOP_C  = 4'd13
  } phase_t;

  // Byte stage within a transaction
  typedef enum logic [2:0] {
    ST_ADDR_W = 3'd0,
    ST_REG    = 3'd1,
    ST_ADDR_R = 3'd2,
    ST_DATA   = 3'd3,
    ST_BLOCK  = 3'd4
  } stage_t;

  // Operation codes
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_READ  = 3'd1;
  localparam logic [2:0] OP_WRITE = 3'd2;
  localparam logic [2:0] OP_BLOCK = 3'd3;
  localparam logic [2:0] OP_PROBE = 3'd4;
  localparam logic [2:0] OP_CLEAR = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] CFG_DELAY       = 2'd0;
  localparam logic [1:0] CFG_PROBE_FIRST = 2'd1;
  localparam logic [1:0] CFG_PROBE_SEC   = 2'd2;

  localparam logic [15:0] DELAY_RESET       = 16'd10;
  localparam logic [7:0]  PROBE_FIRST_RESET = 8'd192;
  localparam logic [7:0]  PROBE_SEC_RESET   = 8'd196;

  localparam logic [7:0] MAX_BLOCK_BYTES = 8'd255;
  localparam logic [3:0] BITS_PER_BYTE   = 4'd8;

endpackage

// ----- src/i2c_register_master.sv -----
// Result: the result word for an input word is registered and shown in the cycle after acceptance.
// Throughput: one word per cycle unless stalled; each word is a tick of the bus sequencer, whose
// next state is computed in a single pass between the state registers and the result register.
// Reset (synchronous, rst_n low): sequencer idle, counters and results cleared, error latch
// cleared, delay 10 ticks, probe candidates 192 and 196, no result word pending.
module i2c_register_master
  import i2crm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_op,
  input  logic [7:0]  in_device,
  input  logic [7:0]  in_reg_index,
  input  logic [7:0]  in_wr_data,
  input  logic [7:0]  in_byte_count,
  input  logic        in_sda_in,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_scl,
  output logic        out_sda_out,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic        out_status,
  output logic [7:0]  out_rd_data,
  output logic [7:0]  out_found_dev,
  output logic        out_byte_taken,
  output logic        out_first_error,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [15:0] cfg_wdata
);

  // configuration registers
  logic [15:0] delay_ticks_r;
  logic [7:0]  probe_first_r;
  logic [7:0]  probe_second_r;

  // sequencer state
  phase_t      phase_r, phase_nxt, phase_cur;
  logic [15:0] delay_cnt_r, delay_cnt_nxt;
  logic [3:0]  bit_idx_r, bit_idx_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [7:0]  bytes_left_r, bytes_left_nxt;
  logic [7:0]  dev_r, dev_nxt;
  logic [7:0]  reg_r, reg_nxt;
  logic [7:0]  data_r, data_nxt;
  logic        probe_idx_r, probe_idx_nxt;
  logic        err_r, err_nxt;
  logic [7:0]  rd_r, rd_nxt;
  logic [7:0]  found_r, found_nxt;
  logic [2:0]  op_kind_r, op_kind_nxt;
  stage_t      stage_r, stage_nxt;
  logic        failed_r, failed_nxt;

  // per-tick outputs
  logic        start_op;
  logic        in_fire;
  logic        busy;
  logic        done;
  logic        status;
  logic        taken;
  logic        scl;
  logic        sda;
  logic [15:0] dt;
  logic        step_end;
  logic [7:0]  shift_in;
  logic [3:0]  bit_inc;

  // result register
  logic        out_valid_r;
  logic        scl_r, sda_r, busy_r, done_r, status_r, taken_r;

  // accept a word whenever the result register is free or being drained
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // an op is taken only while idle
  assign start_op  = (phase_r == PH_IDLE) &&
                     ((in_op == OP_READ) || (in_op == OP_WRITE) ||
                      (in_op == OP_BLOCK) || (in_op == OP_PROBE));
  assign phase_cur = start_op ? PH_START_A : phase_r;
  assign busy      = (phase_cur != PH_IDLE);

  assign dt       = (delay_ticks_r == 16'd0) ? 16'd1 : delay_ticks_r;
  assign step_end = (({1'b0, (start_op ? 16'd0 : delay_cnt_r)} + 17'd1) >= {1'b0, dt});
  assign shift_in = {shift_r[6:0], in_sda_in};
  assign bit_inc  = bit_idx_r + 4'd1;

  // drive the lines for the current phase
  always_comb begin : line_drive
    scl = 1'b1;
    sda = 1'b1;
    unique case (phase_cur)
      PH_IDLE, PH_START_A: begin
        scl = 1'b1;
        sda = 1'b1;
      end
      PH_START_B: begin
        scl = 1'b1;
        sda = 1'b0;
      end
      PH_BIT_LO: begin
        scl = 1'b0;
        sda = shift_r[7];
      end
      PH_BIT_HI: begin
        scl = 1'b1;
        sda = shift_r[7];
      end
      PH_ACK_LO, PH_RBIT_LO, PH_RACK_LO: begin
        scl = 1'b0;
        sda = 1'b1;
      end
      PH_ACK_HI, PH_RBIT_HI, PH_RACK_HI, PH_STOP_C: begin
        scl = 1'b1;
        sda = 1'b1;
      end
      PH_STOP_A: begin
        scl = 1'b0;
        sda = 1'b0;
      end
      PH_STOP_B: begin
        scl = 1'b1;
        sda = 1'b0;
      end
      default: begin
        scl = 1'b1;
        sda = 1'b1;
      end
    endcase
  end

  // next state of the sequencer for one tick
  always_comb begin : next_state
    phase_nxt      = phase_r;
    delay_cnt_nxt  = delay_cnt_r;
    bit_idx_nxt    = bit_idx_r;
    shift_nxt      = shift_r;
    bytes_left_nxt = bytes_left_r;
    dev_nxt        = dev_r;
    reg_nxt        = reg_r;
    data_nxt       = data_r;
    probe_idx_nxt  = probe_idx_r;
    err_nxt        = err_r;
    rd_nxt         = rd_r;
    found_nxt      = found_r;
    op_kind_nxt    = op_kind_r;
    stage_nxt      = stage_r;
    failed_nxt     = failed_r;
    done           = 1'b0;
    status         = 1'b0;
    taken          = 1'b0;

    // take a new op or clear the error latch while idle
    if (phase_r == PH_IDLE) begin
      if (in_op == OP_CLEAR) begin
        err_nxt = 1'b0;
      end else if (start_op) begin
        op_kind_nxt    = in_op;
        delay_cnt_nxt  = 16'd0;
        probe_idx_nxt  = 1'b0;
        bytes_left_nxt = (in_byte_count > MAX_BLOCK_BYTES) ? MAX_BLOCK_BYTES : in_byte_count;
        stage_nxt      = ST_ADDR_W;
        failed_nxt     = 1'b0;
        phase_nxt      = PH_START_A;
        if (in_op == OP_PROBE) begin
          found_nxt = 8'd0;
          dev_nxt   = probe_first_r;
          reg_nxt   = 8'd0;
          data_nxt  = 8'd0;
        end else begin
          dev_nxt  = in_device;
          reg_nxt  = in_reg_index;
          data_nxt = in_wr_data;
        end
      end
    end

    // advance the bus step
    if (busy) begin
      if (!step_end) begin
        delay_cnt_nxt = delay_cnt_nxt + 16'd1;
      end else begin
        delay_cnt_nxt = 16'd0;
        unique case (phase_cur)
          PH_START_A: phase_nxt = PH_START_B;
          PH_START_B: begin
            shift_nxt   = (stage_nxt == ST_ADDR_R) ? (dev_nxt | 8'h01) : (dev_nxt & 8'hFE);
            bit_idx_nxt = 4'd0;
            phase_nxt   = PH_BIT_LO;
          end
          PH_BIT_LO: phase_nxt = PH_BIT_HI;
          PH_BIT_HI: begin
            shift_nxt   = {shift_r[6:0], 1'b0};
            bit_idx_nxt = bit_inc;
            phase_nxt   = (bit_inc >= BITS_PER_BYTE) ? PH_ACK_LO : PH_BIT_LO;
          end
          PH_ACK_LO: phase_nxt = PH_ACK_HI;
          PH_ACK_HI: begin
            if (in_sda_in) begin
              failed_nxt = 1'b1;
              phase_nxt  = PH_STOP_A;
            end else begin
              case (stage_r)
                ST_ADDR_W: begin
                  stage_nxt   = ST_REG;
                  shift_nxt   = reg_r;
                  bit_idx_nxt = 4'd0;
                  phase_nxt   = PH_BIT_LO;
                end
                ST_REG: begin
                  if ((op_kind_r == OP_READ) || (op_kind_r == OP_PROBE)) begin
                    stage_nxt = ST_ADDR_R;
                    phase_nxt = PH_START_A;
                  end else if (op_kind_r == OP_WRITE) begin
                    stage_nxt   = ST_DATA;
                    shift_nxt   = data_r;
                    bit_idx_nxt = 4'd0;
                    phase_nxt   = PH_BIT_LO;
                  end else if (bytes_left_r != 8'd0) begin
                    stage_nxt      = ST_BLOCK;
                    bytes_left_nxt = bytes_left_r - 8'd1;
                    taken          = 1'b1;
                    shift_nxt      = in_wr_data;
                    bit_idx_nxt    = 4'd0;
                    phase_nxt      = PH_BIT_LO;
                  end else begin
                    phase_nxt = PH_STOP_A;
                  end
                end
                ST_ADDR_R: begin
                  shift_nxt   = 8'd0;
                  bit_idx_nxt = 4'd0;
                  phase_nxt   = PH_RBIT_LO;
                end
                ST_BLOCK: begin
                  if (bytes_left_r != 8'd0) begin
                    bytes_left_nxt = bytes_left_r - 8'd1;
                    taken          = 1'b1;
                    shift_nxt      = in_wr_data;
                    bit_idx_nxt    = 4'd0;
                    phase_nxt      = PH_BIT_LO;
                  end else begin
                    phase_nxt = PH_STOP_A;
                  end
                end
                default: phase_nxt = PH_STOP_A;
              endcase
            end
          end
          PH_RBIT_LO: phase_nxt = PH_RBIT_HI;
          PH_RBIT_HI: begin
            shift_nxt   = shift_in;
            bit_idx_nxt = bit_inc;
            if (bit_inc >= BITS_PER_BYTE) begin
              if (op_kind_r == OP_READ) begin
                rd_nxt = shift_in;
              end
              phase_nxt = PH_RACK_LO;
            end else begin
              phase_nxt = PH_RBIT_LO;
            end
          end
          PH_RACK_LO: phase_nxt = PH_RACK_HI;
          PH_RACK_HI: phase_nxt = PH_STOP_A;
          PH_STOP_A:  phase_nxt = PH_STOP_B;
          PH_STOP_B:  phase_nxt = PH_STOP_C;
          PH_STOP_C: begin
            if (failed_r) begin
              err_nxt = 1'b1;
            end
            if ((op_kind_r == OP_PROBE) && failed_r && !probe_idx_r) begin
              // retry the probe at the second candidate
              probe_idx_nxt = 1'b1;
              dev_nxt       = probe_second_r;
              reg_nxt       = 8'd0;
              data_nxt      = 8'd0;
              stage_nxt     = ST_ADDR_W;
              failed_nxt    = 1'b0;
              phase_nxt     = PH_START_A;
            end else begin
              if ((op_kind_r == OP_PROBE) && !failed_r) begin
                found_nxt = dev_r;
              end
              done      = 1'b1;
              status    = failed_r;
              phase_nxt = PH_IDLE;
            end
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_ticks_r  <= DELAY_RESET;
      probe_first_r  <= PROBE_FIRST_RESET;
      probe_second_r <= PROBE_SEC_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_DELAY:       delay_ticks_r  <= cfg_wdata;
        CFG_PROBE_FIRST: probe_first_r  <= cfg_wdata[7:0];
        CFG_PROBE_SEC:   probe_second_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // sequencer state: advance one tick per accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      delay_cnt_r  <= 16'd0;
      bit_idx_r    <= 4'd0;
      shift_r      <= 8'd0;
      bytes_left_r <= 8'd0;
      dev_r        <= 8'd0;
      reg_r        <= 8'd0;
      data_r       <= 8'd0;
      probe_idx_r  <= 1'b0;
      err_r        <= 1'b0;
      rd_r         <= 8'd0;
      found_r      <= 8'd0;
      op_kind_r    <= OP_NONE;
      stage_r      <= ST_ADDR_W;
      failed_r     <= 1'b0;
    end else if (in_fire) begin
      phase_r      <= phase_nxt;
      delay_cnt_r  <= delay_cnt_nxt;
      bit_idx_r    <= bit_idx_nxt;
      shift_r      <= shift_nxt;
      bytes_left_r <= bytes_left_nxt;
      dev_r        <= dev_nxt;
      reg_r        <= reg_nxt;
      data_r       <= data_nxt;
      probe_idx_r  <= probe_idx_nxt;
      err_r        <= err_nxt;
      rd_r         <= rd_nxt;
      found_r      <= found_nxt;
      op_kind_r    <= op_kind_nxt;
      stage_r      <= stage_nxt;
      failed_r     <= failed_nxt;
    end
  end

  // result word valid: set on accept, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result word payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      scl_r    <= scl;
      sda_r    <= sda;
      busy_r   <= busy;
      done_r   <= done;
      status_r <= status;
      taken_r  <= taken;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_scl         = scl_r;
  assign out_sda_out     = sda_r;
  assign out_busy_res    = busy_r;
  assign out_done_res    = done_r;
  assign out_status      = status_r;
  assign out_rd_data     = rd_r;
  assign out_found_dev   = found_r;
  assign out_byte_taken  = taken_r;
  assign out_first_error = err_r;

endmodule
